// ===== design/lshp_pkg.sv =====
// ----------------------------------------------------------------------------
// lshp_pkg: shared types and constants
// Field widths, register and mode codes, and the tap control struct used by
// the six-tap half-pel interpolator.
// ----------------------------------------------------------------------------
package lshp_pkg;

  localparam int PIX_W   = 8;
  localparam int ENTRY_W = 40;   // five stacked rows of one window column
  localparam int INTER_W = 15;   // signed vertical intermediate
  localparam int MODE_W  = 2;
  localparam int SIZE_W  = 6;
  localparam int CFG_AW  = 4;
  localparam int CFG_DW  = 32;
  localparam int REG_IDX_W = 2;

  // First window row and column that yield an output pixel
  localparam int FIRST_OUT = 5;
  // Window side exceeds the output block side by this plus one
  localparam int BORDER = 4;

  localparam logic [REG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 2'd2;

  localparam logic [MODE_W-1:0] MODE_HORZ = 2'd0;
  localparam logic [MODE_W-1:0] MODE_VERT = 2'd1;
  // any other code selects the center (two-dimensional) filter

  localparam logic [SIZE_W-1:0] RESET_SIZE = 6'd16;

  typedef logic [PIX_W-1:0]   pix_t;
  typedef logic [ENTRY_W-1:0] entry_t;

  typedef struct packed {
    logic shift;   // one column beat moves through the taps
    logic clear;   // restart after a register write
  } tap_ctl_t;

endpackage

// ===== design/lshp_cfg.sv =====
// ----------------------------------------------------------------------------
// lshp_cfg: configuration registers
// APB-style register file for filter mode and block size; any write to a
// defined register pulses restart.
// ----------------------------------------------------------------------------
module lshp_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lshp_pkg::CFG_AW-1:0]       paddr,
  input  logic [lshp_pkg::CFG_DW-1:0]       pwdata,
  output logic [lshp_pkg::CFG_DW-1:0]       prdata,
  output logic                              pready,
  output logic [lshp_pkg::MODE_W-1:0]       mode,
  output logic [lshp_pkg::SIZE_W-1:0]       width_cfg,
  output logic [lshp_pkg::SIZE_W-1:0]       height_cfg,
  output logic                              restart
);

  logic                               wr;
  logic [lshp_pkg::REG_IDX_W-1:0]     idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[lshp_pkg::CFG_AW-1:2];

  assign restart = wr && ((idx == lshp_pkg::REG_MODE) || (idx == lshp_pkg::REG_WIDTH) ||
                          (idx == lshp_pkg::REG_HEIGHT));

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= lshp_pkg::MODE_HORZ;
      width_cfg  <= lshp_pkg::RESET_SIZE;
      height_cfg <= lshp_pkg::RESET_SIZE;
    end else if (wr) begin
      case (idx)
        lshp_pkg::REG_MODE:   mode       <= pwdata[lshp_pkg::MODE_W-1:0];
        lshp_pkg::REG_WIDTH:  width_cfg  <= pwdata[lshp_pkg::SIZE_W-1:0];
        lshp_pkg::REG_HEIGHT: height_cfg <= pwdata[lshp_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      lshp_pkg::REG_MODE:   prdata = lshp_pkg::CFG_DW'(mode);
      lshp_pkg::REG_WIDTH:  prdata = lshp_pkg::CFG_DW'(width_cfg);
      lshp_pkg::REG_HEIGHT: prdata = lshp_pkg::CFG_DW'(height_cfg);
      default:              prdata = '0;
    endcase
  end

endmodule

// ===== design/lshp_line_mem.sv =====
// ----------------------------------------------------------------------------
// lshp_line_mem: row store
// One entry per window column holding the five previous rows; synchronous
// write port and registered read port.
// ----------------------------------------------------------------------------
module lshp_line_mem #(
  parameter int DEPTH = 37,
  parameter int AW    = 6
) (
  input  logic                  clk,
  input  logic                  rd_en,
  input  logic [AW-1:0]         rd_addr,
  output lshp_pkg::entry_t      rd_data,
  input  logic                  wr_en,
  input  logic [AW-1:0]         wr_addr,
  input  lshp_pkg::entry_t      wr_data
);

  lshp_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/lshp_tap_filter.sv =====
// ----------------------------------------------------------------------------
// lshp_tap_filter: tap registers and six-tap filters
// Computes the vertical intermediate of each column beat, keeps the pixel and
// intermediate tap lines, and forms the rounded, clipped output pixel.
// ----------------------------------------------------------------------------
module lshp_tap_filter (
  input  logic                          clk,
  input  logic                          rst,
  input  lshp_pkg::tap_ctl_t            ctl,
  input  logic [lshp_pkg::MODE_W-1:0]   mode,
  input  lshp_pkg::entry_t              entry,
  input  lshp_pkg::pix_t                cur,
  output lshp_pkg::pix_t                pix
);

  localparam int SUM_W = 22;
  localparam int RND_W = SUM_W + 1;

  lshp_pkg::pix_t                       ptap [6];
  logic signed [lshp_pkg::INTER_W-1:0]  itap [6];
  logic signed [lshp_pkg::INTER_W-1:0]  vert;
  logic signed [SUM_W-1:0]              h_sum;
  logic signed [SUM_W-1:0]              c_sum;
  lshp_pkg::pix_t                       h_pix;
  lshp_pkg::pix_t                       v_pix;
  lshp_pkg::pix_t                       c_pix;

  function automatic logic signed [SUM_W-1:0] zx(input lshp_pkg::pix_t x);
    return $signed(SUM_W'(x));
  endfunction

  function automatic logic signed [SUM_W-1:0] sx(input logic signed [lshp_pkg::INTER_W-1:0] x);
    return SUM_W'(x);
  endfunction

  function automatic logic signed [SUM_W-1:0] six_tap(
    input logic signed [SUM_W-1:0] a, input logic signed [SUM_W-1:0] b,
    input logic signed [SUM_W-1:0] c, input logic signed [SUM_W-1:0] d,
    input logic signed [SUM_W-1:0] e, input logic signed [SUM_W-1:0] f
  );
    return (a + f) - (b + e) * 22'sd5 + (c + d) * 22'sd20;
  endfunction

  function automatic lshp_pkg::pix_t round_clip(input logic signed [SUM_W-1:0] x,
                                                input logic center);
    logic signed [RND_W-1:0] v;
    logic        [RND_W-1:0] r;
    lshp_pkg::pix_t          res;
    v = RND_W'(x) + (center ? 23'sd512 : 23'sd16);
    r = center ? ($unsigned(v) >> 10) : ($unsigned(v) >> 5);
    if (v < 0) begin
      res = '0;
    end else if (r > RND_W'(255)) begin
      res = 8'hFF;
    end else begin
      res = r[lshp_pkg::PIX_W-1:0];
    end
    return res;
  endfunction

  // entry byte 4 is the oldest row, byte 0 the newest; cur completes the column
  assign vert = lshp_pkg::INTER_W'(six_tap(zx(entry[39:32]), zx(entry[31:24]),
                                           zx(entry[23:16]), zx(entry[15:8]),
                                           zx(entry[7:0]),   zx(cur)));

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      for (int i = 0; i < 6; i++) begin
        ptap[i] <= '0;
        itap[i] <= '0;
      end
    end else if (ctl.shift) begin
      for (int i = 0; i < 5; i++) begin
        ptap[i] <= ptap[i+1];
        itap[i] <= itap[i+1];
      end
      // window row three above the current one feeds the horizontal taps
      ptap[5] <= entry[23:16];
      itap[5] <= vert;
    end
  end

  assign h_sum = six_tap(zx(ptap[0]), zx(ptap[1]), zx(ptap[2]),
                         zx(ptap[3]), zx(ptap[4]), zx(ptap[5]));
  assign c_sum = six_tap(sx(itap[0]), sx(itap[1]), sx(itap[2]),
                         sx(itap[3]), sx(itap[4]), sx(itap[5]));

  assign h_pix = round_clip(h_sum, 1'b0);
  assign v_pix = round_clip(sx(itap[2]), 1'b0);
  assign c_pix = round_clip(c_sum, 1'b1);

  always_comb begin
    case (mode)
      lshp_pkg::MODE_HORZ: pix = h_pix;
      lshp_pkg::MODE_VERT: pix = v_pix;
      default:             pix = c_pix;
    endcase
  end

endmodule

// ===== design/luma_sixtap_halfpel_interp_unit.sv =====
// ----------------------------------------------------------------------------
// luma_sixtap_halfpel_interp_unit: six-tap half-pel luma interpolator
// Raster window in, one half-pel pixel per beat once six rows and columns
// are present; horizontal, vertical and center modes.
// ----------------------------------------------------------------------------
// Source samples of a (width+5) by (height+5) window enter one per beat in
// raster order; the block sustains one sample per clock while the output is
// not stalled. Each sample passes the read stage, where the row store read
// issued at acceptance is registered, then the filter stage, where the
// read-modify-write of that column and the tap shift take place, before the
// filter loads the output register. The rate is set by the row store, which
// can take one read and one write every cycle. The row store has no clearing
// pass and is usable right after reset. A register write restarts the
// window; write only while the block is idle.
// ----------------------------------------------------------------------------
module luma_sixtap_halfpel_interp_unit #(
  parameter int MAX_WIDTH  = 32,
  parameter int MAX_HEIGHT = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lshp_pkg::CFG_AW-1:0]     paddr,
  input  logic [lshp_pkg::CFG_DW-1:0]     pwdata,
  output logic [lshp_pkg::CFG_DW-1:0]     prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      src_pixel,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      interp_pixel,
  output logic                            last_of_block
);

  localparam int DEPTH = MAX_WIDTH + 5;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(MAX_HEIGHT + 5);
  localparam logic [6:0] MAX_W7 = 7'(MAX_WIDTH);
  localparam logic [6:0] MAX_H7 = 7'(MAX_HEIGHT);

  logic [lshp_pkg::MODE_W-1:0]  mode;
  logic [lshp_pkg::SIZE_W-1:0]  width_cfg;
  logic [lshp_pkg::SIZE_W-1:0]  height_cfg;
  logic                         restart;

  logic [6:0]                   eff_w;
  logic [6:0]                   eff_h;
  logic [AW-1:0]                col_lim;
  logic [RW-1:0]                row_lim;
  logic [AW-1:0]                col;
  logic [RW-1:0]                row;

  logic                         accept;
  logic                         out_free;
  logic                         s2_can_load;
  logic                         s1_move;

  logic                         s1_valid;
  logic [AW-1:0]                s1_col;
  lshp_pkg::pix_t               s1_cur;
  logic                         s1_produce;
  logic                         s1_last;
  logic                         s2_valid;
  logic                         s2_last;

  lshp_pkg::entry_t             rd_data;
  lshp_pkg::tap_ctl_t           tap_ctl;
  lshp_pkg::pix_t               filt_pix;

  function automatic logic [6:0] eff_size(input logic [lshp_pkg::SIZE_W-1:0] v,
                                          input logic [6:0] mx);
    logic [6:0] res;
    if (v == '0) begin
      res = 7'd1;
    end else if (7'(v) > mx) begin
      res = mx;
    end else begin
      res = 7'(v);
    end
    return res;
  endfunction

  lshp_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .mode       (mode),
    .width_cfg  (width_cfg),
    .height_cfg (height_cfg),
    .restart    (restart)
  );

  assign eff_w   = eff_size(width_cfg, MAX_W7);
  assign eff_h   = eff_size(height_cfg, MAX_H7);
  assign col_lim = AW'(eff_w + 7'(lshp_pkg::BORDER));
  assign row_lim = RW'(eff_h + 7'(lshp_pkg::BORDER));

  // Pipeline flow: output register, then filter stage, then read stage
  assign out_free    = !out_valid || !out_stall;
  assign s2_can_load = !s2_valid || out_free;
  assign s1_move     = s1_valid && s2_can_load;
  assign in_stall    = s1_valid && !s2_can_load;
  assign accept      = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col >= col_lim) begin
        col <= '0;
        row <= (row >= row_lim) ? '0 : row + RW'(1);
      end else begin
        col <= col + AW'(1);
      end
    end
  end

  // A column is read again only a full window row later, so the read and
  // write-back of the same entry never overlap.
  lshp_line_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_line_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col),
    .rd_data (rd_data),
    .wr_en   (s1_move),
    .wr_addr (s1_col),
    .wr_data ({rd_data[31:0], s1_cur})
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col     <= col;
      s1_cur     <= src_pixel;
      s1_produce <= (col >= AW'(lshp_pkg::FIRST_OUT)) && (row >= RW'(lshp_pkg::FIRST_OUT));
      s1_last    <= (col >= col_lim) && (row >= row_lim);
    end
  end

  assign tap_ctl.shift = s1_move;
  assign tap_ctl.clear = restart;

  lshp_tap_filter u_tap_filter (
    .clk   (clk),
    .rst   (rst),
    .ctl   (tap_ctl),
    .mode  (mode),
    .entry (rd_data),
    .cur   (s1_cur),
    .pix   (filt_pix)
  );

  // Filter stage: taps hold this beat's window until it moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_move) begin
      s2_valid <= s1_produce;
    end else if (s2_valid && out_free) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_last <= s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s2_valid) begin
      interp_pixel  <= filt_pix;
      last_of_block <= s2_last;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (col <= col_lim) && (row <= row_lim))
    else $error("window counters beyond block limits");

  a_last_produces: assert property (@(posedge clk) disable iff (rst)
    s1_move && s1_last |=> s2_valid && s2_last)
    else $error("last window sample did not reach the filter stage");

  a_bubble_drops: assert property (@(posedge clk) disable iff (rst)
    s1_move && !s1_produce |=> !s2_valid)
    else $error("border sample loaded the filter stage");

endmodule

// ===== dv/lshp_interp_checker.sv =====
// ----------------------------------------------------------------------------
// lshp_interp_checker: scoreboard for the six-tap half-pel interpolator
// Watches the register port and both pixel channels, keeps its own copy of
// the column store, taps and window counters, works out the pixel each
// accepted source beat yields and compares it with the output beats in order.
// ----------------------------------------------------------------------------
module lshp_interp_checker #(
  parameter int MAX_WIDTH  = 32,
  parameter int MAX_HEIGHT = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [lshp_pkg::CFG_AW-1:0] paddr,
  input  logic [lshp_pkg::CFG_DW-1:0] pwdata,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  lshp_pkg::pix_t              src_pixel,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  lshp_pkg::pix_t              interp_pixel,
  input  logic                        last_of_block,
  output int                          mismatches,
  output int                          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_ONE  = 16;
  localparam int SHIFT_ONE = 5;
  localparam int HALF_TWO  = 512;
  localparam int SHIFT_TWO = 10;
  localparam int COLS      = MAX_WIDTH + lshp_pkg::BORDER + 1;

  typedef struct packed {
    lshp_pkg::pix_t pixel;
    logic           last;
  } interp_beat_t;

  interp_beat_t pending_pixels[$];

  logic [lshp_pkg::MODE_W-1:0]  mode_r;
  logic [lshp_pkg::SIZE_W-1:0]  width_r;
  logic [lshp_pkg::SIZE_W-1:0]  height_r;
  lshp_pkg::entry_t             col_store [COLS];
  logic [6*lshp_pkg::PIX_W-1:0] row_taps;
  int                           vert_taps [6];
  int                           col_n;
  int                           row_n;

  function automatic int six_tap(input int a, input int b, input int c,
                                 input int d, input int e, input int f);
    return (a + f) - 5 * (b + e) + 20 * (c + d);
  endfunction

  function automatic lshp_pkg::pix_t round_clip(input int x, input int half,
                                                input int shift);
    int v;
    v = x + half;
    if (v < 0) return '0;
    v = v >>> shift;
    return (v > 255) ? lshp_pkg::pix_t'(255) : lshp_pkg::pix_t'(v);
  endfunction

  function automatic int clamp_size(input logic [lshp_pkg::SIZE_W-1:0] v, input int limit);
    if (v == 0) return 1;
    return (int'(v) > limit) ? limit : int'(v);
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] lshp checker: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic restart_window();
    row_taps = '0;
    foreach (vert_taps[i]) vert_taps[i] = 0;
    col_n = 0;
    row_n = 0;
  endtask

  task automatic write_register(input logic [lshp_pkg::CFG_AW-1:0] addr,
                                input logic [lshp_pkg::CFG_DW-1:0] data);
    case (addr[lshp_pkg::CFG_AW-1:2])
      lshp_pkg::REG_MODE:   mode_r = data[lshp_pkg::MODE_W-1:0];
      lshp_pkg::REG_WIDTH:  width_r = data[lshp_pkg::SIZE_W-1:0];
      lshp_pkg::REG_HEIGHT: height_r = data[lshp_pkg::SIZE_W-1:0];
      default:              return;
    endcase
    restart_window();
  endtask

  task automatic filter_beat(input lshp_pkg::pix_t pix);
    int               w;
    int               h;
    int               idx;
    int               vsum;
    int               p [6];
    lshp_pkg::entry_t entry;
    interp_beat_t     beat;
    w = clamp_size(width_r, MAX_WIDTH);
    h = clamp_size(height_r, MAX_HEIGHT);
    idx = (col_n < COLS) ? col_n : COLS - 1;
    entry = col_store[idx];
    // oldest row first, the new sample closes the column
    for (int i = 0; i < 5; i++) p[i] = entry[8*(4-i) +: 8];
    p[5] = pix;
    vsum = six_tap(p[0], p[1], p[2], p[3], p[4], p[5]);
    row_taps = {row_taps[5*lshp_pkg::PIX_W-1:0], entry[23:16]};
    for (int i = 0; i < 5; i++) vert_taps[i] = vert_taps[i+1];
    vert_taps[5] = vsum;
    col_store[idx] = {entry[31:0], pix};
    if (row_n >= lshp_pkg::FIRST_OUT && col_n >= lshp_pkg::FIRST_OUT) begin
      if (mode_r == lshp_pkg::MODE_HORZ)
        beat.pixel = round_clip(six_tap(row_taps[47:40], row_taps[39:32], row_taps[31:24],
                                        row_taps[23:16], row_taps[15:8], row_taps[7:0]),
                                HALF_ONE, SHIFT_ONE);
      else if (mode_r == lshp_pkg::MODE_VERT)
        beat.pixel = round_clip(vert_taps[2], HALF_ONE, SHIFT_ONE);
      else
        beat.pixel = round_clip(six_tap(vert_taps[0], vert_taps[1], vert_taps[2],
                                        vert_taps[3], vert_taps[4], vert_taps[5]),
                                HALF_TWO, SHIFT_TWO);
      beat.last = (row_n >= h + lshp_pkg::BORDER) && (col_n >= w + lshp_pkg::BORDER);
      pending_pixels.push_back(beat);
    end
    // advance the window position, wrap at the end of the block
    if (col_n >= w + lshp_pkg::BORDER) begin
      col_n = 0;
      row_n = (row_n >= h + lshp_pkg::BORDER) ? 0 : row_n + 1;
    end else begin
      col_n++;
    end
  endtask

  task automatic check_beat();
    interp_beat_t want;
    if (pending_pixels.size() == 0) begin
      report_mismatch($sformatf("unexpected pixel %0d last %0b", interp_pixel, last_of_block));
      return;
    end
    want = pending_pixels.pop_front();
    if (interp_pixel !== want.pixel)
      report_mismatch($sformatf("interp_pixel %0d, want %0d", interp_pixel, want.pixel));
    if (last_of_block !== want.last)
      report_mismatch($sformatf("last_of_block %0b, want %0b", last_of_block, want.last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mode_r = lshp_pkg::MODE_HORZ;
      width_r = lshp_pkg::RESET_SIZE;
      height_r = lshp_pkg::RESET_SIZE;
      foreach (col_store[i]) col_store[i] = '0;
      restart_window();
      pending_pixels.delete();
      mismatches = 0;
    end else begin
      if (psel && penable && pwrite && pready) write_register(paddr, pwdata);
      if (in_valid && !in_stall) filter_beat(src_pixel);
      if (out_valid && !out_stall) check_beat();
    end
    outstanding <= pending_pixels.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for luma_sixtap_halfpel_interp_unit
// Streams raster windows of source samples under several filter modes and
// block sizes, with random gaps and stalls on both channels and one long
// output hold; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W        = 32;
  localparam int MAX_H        = 32;
  localparam int DRAIN_CYCLES = 12;
  localparam int LONG_HOLD    = 300;
  localparam int RANDOM_ITEMS = 250;
  localparam int CALM_TAIL    = 100;
  localparam int LIMIT        = 300000;

  localparam logic [lshp_pkg::MODE_W-1:0] MODE_CENTER = 2'd2;
  localparam logic [lshp_pkg::MODE_W-1:0] MODE_SPARE  = 2'd3;

  typedef enum int {PAT_NOISE, PAT_RAILS, PAT_PEAK, PAT_TROUGH, PAT_FLAT} pattern_e;

  logic                        clk       = 1'b0;
  logic                        rst       = 1'b1;
  logic                        psel      = 1'b0;
  logic                        penable   = 1'b0;
  logic                        pwrite    = 1'b0;
  logic [lshp_pkg::CFG_AW-1:0] paddr     = '0;
  logic [lshp_pkg::CFG_DW-1:0] pwdata    = '0;
  logic [lshp_pkg::CFG_DW-1:0] prdata;
  logic                        pready;
  logic                        in_valid  = 1'b0;
  logic                        in_stall;
  lshp_pkg::pix_t              src_pixel = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  lshp_pkg::pix_t              interp_pixel;
  logic                        last_of_block;

  int mismatches;
  int outstanding;
  int cycles      = 0;
  int sent        = 0;
  int holds_asked = 0;
  int holds_done  = 0;
  bit calm        = 1'b0;

  luma_sixtap_halfpel_interp_unit #(.MAX_WIDTH(MAX_W), .MAX_HEIGHT(MAX_H)) i_dut (.*);

  lshp_interp_checker #(.MAX_WIDTH(MAX_W), .MAX_HEIGHT(MAX_H)) i_checker (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // output side: random stall bursts, plus the long hold when asked
  initial begin
    forever begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
        holds_done++;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic int window_side(input logic [lshp_pkg::SIZE_W-1:0] v, input int limit);
    int n;
    n = (v == 0) ? 1 : ((int'(v) > limit) ? limit : int'(v));
    return n + lshp_pkg::BORDER + 1;
  endfunction

  function automatic lshp_pkg::pix_t pattern_pixel(input pattern_e kind, input int r,
                                                   input int c);
    bit hot;
    hot = ((r % 6) == 2 || (r % 6) == 3) && ((c % 6) == 2 || (c % 6) == 3);
    case (kind)
      PAT_RAILS:  return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      PAT_PEAK:   return hot ? 8'hFF : 8'h00;
      PAT_TROUGH: return hot ? 8'h00 : 8'hFF;
      PAT_FLAT:   return lshp_pkg::pix_t'($urandom_range(120, 135));
      default:    return lshp_pkg::pix_t'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic wait_drained();
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic settle();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [lshp_pkg::REG_IDX_W-1:0] idx,
                           input logic [lshp_pkg::CFG_DW-1:0] value, input int bits);
    logic [lshp_pkg::CFG_DW-1:0] junk;
    junk = $urandom;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= (junk << bits) | value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_pixel(input lshp_pkg::pix_t pix);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    src_pixel <= pix;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic run_phase(input logic [lshp_pkg::MODE_W-1:0] mode,
                           input logic [lshp_pkg::SIZE_W-1:0] wreg,
                           input logic [lshp_pkg::SIZE_W-1:0] hreg, input int blocks,
                           input pattern_e kind, input bit hold, input bit pause,
                           input bit partial);
    int cols;
    int rows;
    int extra;
    cols = window_side(wreg, MAX_W);
    rows = window_side(hreg, MAX_H);
    settle();
    write_reg(lshp_pkg::REG_MODE, lshp_pkg::CFG_DW'(mode), lshp_pkg::MODE_W);
    write_reg(lshp_pkg::REG_WIDTH, lshp_pkg::CFG_DW'(wreg), lshp_pkg::SIZE_W);
    write_reg(lshp_pkg::REG_HEIGHT, lshp_pkg::CFG_DW'(hreg), lshp_pkg::SIZE_W);
    for (int b = 0; b < blocks; b++)
      for (int r = 0; r < rows; r++)
        for (int c = 0; c < cols; c++) begin
          if (b == 0 && c == 0 && hold && r == lshp_pkg::FIRST_OUT) holds_asked++;
          if (b == 0 && c == 0 && pause && r == rows - 1) begin
            // hold the source until every pending pixel is out
            in_valid <= 1'b0;
            wait_drained();
          end
          send_pixel(pattern_pixel(kind, r, c));
        end
    if (partial) begin
      // drop the block midway; the next register write restarts the window
      extra = $urandom_range(1, rows * cols - 1);
      for (int k = 0; k < extra; k++) send_pixel(pattern_pixel(kind, k / cols, k % cols));
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    int                          base;
    logic [lshp_pkg::MODE_W-1:0] mode;
    logic [lshp_pkg::SIZE_W-1:0] wreg;
    logic [lshp_pkg::SIZE_W-1:0] hreg;
    pattern_e                    kind;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    run_phase(lshp_pkg::MODE_HORZ, 6'd1, 6'd1, 1, PAT_PEAK, 1'b0, 1'b0, 1'b0);
    run_phase(lshp_pkg::MODE_VERT, 6'd1, 6'd1, 1, PAT_TROUGH, 1'b0, 1'b0, 1'b0);
    run_phase(MODE_SPARE, 6'd0, 6'd0, 1, PAT_PEAK, 1'b0, 1'b0, 1'b0);
    run_phase(MODE_CENTER, 6'd63, 6'd0, 1, PAT_NOISE, 1'b0, 1'b0, 1'b0);
    run_phase(lshp_pkg::MODE_VERT, 6'd0, 6'd63, 1, PAT_RAILS, 1'b0, 1'b0, 1'b0);

    base = sent;
    run_phase(lshp_pkg::MODE_HORZ, 6'd4, 6'd3, 2, PAT_NOISE, 1'b1, 1'b1, 1'b0);
    while (sent - base < RANDOM_ITEMS) begin
      calm = (sent - base > RANDOM_ITEMS - CALM_TAIL) || ($urandom_range(0, 3) == 0);
      mode = lshp_pkg::MODE_W'($urandom_range(0, 3));
      case ($urandom_range(0, 7))
        0: begin
          wreg = lshp_pkg::SIZE_W'($urandom_range(0, 63));
          hreg = lshp_pkg::SIZE_W'($urandom_range(0, 3));
        end
        1: begin
          wreg = lshp_pkg::SIZE_W'($urandom_range(0, 3));
          hreg = lshp_pkg::SIZE_W'($urandom_range(0, 63));
        end
        default: begin
          wreg = lshp_pkg::SIZE_W'($urandom_range(1, 6));
          hreg = lshp_pkg::SIZE_W'($urandom_range(1, 6));
        end
      endcase
      kind = $urandom_range(0, 1) ? PAT_NOISE : pattern_e'($urandom_range(0, 4));
      run_phase(mode, wreg, hreg, $urandom_range(1, 2), kind, 1'b0, 1'b0,
                $urandom_range(0, 3) == 0);
    end
    calm = 1'b1;

    settle();
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
